[design/olt_pkg.sv]
package olt_pkg;

    localparam logic [1:0] K_CHAR = 2'd0;
    localparam logic [1:0] K_TEND = 2'd1;
    localparam logic [1:0] K_LEND = 2'd2;
    localparam logic [1:0] K_EOF  = 2'd3;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // Pending-store counts and indexes cover the largest supported depth (60, plus overflow).
    localparam int PCNT_W = 6;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = 2;

    typedef enum logic [1:0] {
        M_EMPTY = 2'd0,
        M_SPACE = 2'd1,
        M_TOKEN = 2'd2,
        M_QUOTE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        BK_IDLE       = 2'd0,
        BK_FLUSH_RD   = 2'd1,
        BK_FLUSH_EMIT = 2'd2,
        BK_OPS        = 2'd3
    } t_back_state;

    // Results after the pending flush, in emission order.
    typedef struct packed {
        logic bslash;
        logic chr;
        logic tend;
        logic lend;
        logic eof;
    } t_ops;

    typedef struct packed {
        t_ops              ops;
        logic [7:0]        char_b;
        logic [PCNT_W-1:0] flush_n;
        logic              ovf_all;
        logic              ovf_drop;
        logic              push;
        logic [PCNT_W-1:0] push_idx;
        logic [7:0]        push_char;
        logic [7:0]        tab;
        logic [15:0]       line;
    } t_cmd;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0B) ||
               (c == 8'h0C) || (c == 8'h0D);
    endfunction

endpackage

[design/olt_in_if.sv]
interface olt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_file;

    modport source (output valid, output in_byte, output end_of_file, input ready);
    modport sink (input valid, input in_byte, input end_of_file, output ready);
endinterface

[design/olt_out_if.sv]
interface olt_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_char;
    logic [1:0]  kind;
    logic [7:0]  tab_level;
    logic [15:0] line_count;
    logic        ws_overflow;
    logic        last;

    modport source (output valid, output out_char, output kind, output tab_level,
                    output line_count, output ws_overflow, output last, input ready);
    modport sink (input valid, input out_char, input kind, input tab_level,
                  input line_count, input ws_overflow, input last, output ready);
endinterface

[design/olt_ram.sv]
module olt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                      i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                      o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/olt_cmd_queue.sv]
module olt_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  olt_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output olt_pkg::t_cmd o_head,
    output logic          o_empty
);

    localparam int AW = olt_pkg::CMDQ_AW;

    olt_pkg::t_cmd r_mem [olt_pkg::CMDQ_DEPTH];
    logic [AW:0]   r_wp;
    logic [AW:0]   r_rp;

    assign o_empty = (r_wp == r_rp);
    assign o_full  = (r_wp[AW] != r_rp[AW]) && (r_wp[AW-1:0] == r_rp[AW-1:0]);
    assign o_head  = r_mem[r_rp[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wp[AW-1:0]] <= i_cmd;
        end
    end

endmodule

[design/olt_front.sv]
module olt_front #(
    parameter int LINE_BUF_LEN  = 256,
    parameter int PENDING_DEPTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_wdata,
    olt_in_if.sink        i_in,
    input  logic          i_q_full,
    output logic          o_q_push,
    output olt_pkg::t_cmd o_q_cmd
);

    localparam int LIM_CAP = (LINE_BUF_LEN - 1 > 255) ? 255 : LINE_BUF_LEN - 1;
    localparam logic [olt_pkg::PCNT_W-1:0] PD = olt_pkg::PCNT_W'(PENDING_DEPTH);

    logic [7:0]                  r_limit;
    olt_pkg::t_mode              r_mode,   n_mode;
    logic                        r_held,   n_held;
    logic                        r_rawbs,  n_rawbs;
    logic                        r_incom,  n_incom;
    logic                        r_first,  n_first;
    logic [7:0]                  r_kept,   n_kept;
    logic [olt_pkg::PCNT_W-1:0]  r_pcnt,   n_pcnt;
    logic [7:0]                  r_level,  n_level;
    logic [15:0]                 r_nl,     n_nl;

    logic                        accept;
    logic [7:0]                  lim;
    olt_pkg::t_cmd               cmd;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;
    assign lim        = (r_limit > 8'(LIM_CAP)) ? 8'(LIM_CAP) : r_limit;

    always_comb begin
        logic [7:0] c;
        logic       do_rel;
        logic       do_tok;
        logic       do_endline;
        logic       set_held;
        logic       do_reset;

        c          = i_in.in_byte;
        do_rel     = 1'b0;
        do_tok     = 1'b0;
        do_endline = 1'b0;
        set_held   = 1'b0;
        do_reset   = 1'b0;

        n_mode  = r_mode;
        n_held  = r_held;
        n_rawbs = r_rawbs;
        n_incom = r_incom;
        n_first = r_first;
        n_kept  = r_kept;
        n_pcnt  = r_pcnt;
        n_level = r_level;
        n_nl    = r_nl;
        cmd     = '0;

        if (accept) begin
            if (i_in.end_of_file) begin
                cmd.ops.eof = 1'b1;
                do_reset    = 1'b1;
            end else if (c == olt_pkg::CH_NL) begin
                n_nl = r_nl + 16'd1;
                if (r_rawbs) begin
                    // Backslash-newline joins the lines; a kept backslash gives back its slot.
                    if (r_held) begin
                        n_held = 1'b0;
                        if (r_kept != 8'd0) begin
                            n_kept = r_kept - 8'd1;
                        end
                    end
                    n_rawbs = 1'b0;
                end else begin
                    do_rel     = !r_incom && r_held;
                    do_endline = 1'b1;
                end
            end else begin
                if (!r_incom && (r_kept < lim)) begin
                    if (c == olt_pkg::CH_HASH) begin
                        do_rel  = r_held;
                        n_incom = 1'b1;
                    end else begin
                        n_kept = r_kept + 8'd1;
                        do_rel = r_held;
                        if (c == olt_pkg::CH_BSLASH) begin
                            set_held = 1'b1;
                        end else if (c == olt_pkg::CH_NUL) begin
                            n_incom = 1'b1;
                        end else begin
                            do_tok = 1'b1;
                        end
                    end
                end
                n_rawbs = (c == olt_pkg::CH_BSLASH);
            end

            // The held backslash goes out as an ordinary token character.
            if (do_rel) begin
                n_held = 1'b0;
                cmd.ops.bslash = 1'b1;
                if (n_mode != olt_pkg::M_QUOTE) begin
                    if (n_pcnt != '0) begin
                        cmd.flush_n = (n_pcnt > PD) ? PD : n_pcnt;
                        cmd.ovf_all = (n_pcnt > PD);
                        n_pcnt      = '0;
                    end
                    n_mode = olt_pkg::M_TOKEN;
                end
            end
            if (set_held) begin
                n_held = 1'b1;
            end

            if (do_tok) begin
                if (n_mode == olt_pkg::M_EMPTY || n_mode == olt_pkg::M_SPACE) begin
                    if (olt_pkg::is_ws(c)) begin
                        if (n_first && (c == olt_pkg::CH_TAB) && (n_level != 8'd255)) begin
                            n_level = n_level + 8'd1;
                        end
                        n_mode = olt_pkg::M_SPACE;
                    end else if (c == olt_pkg::CH_COMMA) begin
                        cmd.ovf_drop = cmd.ovf_drop || (n_pcnt > PD);
                        n_pcnt       = '0;
                        cmd.ops.tend = 1'b1;
                        n_mode       = olt_pkg::M_EMPTY;
                        n_first      = 1'b0;
                    end else begin
                        if (n_pcnt != '0) begin
                            cmd.flush_n = (n_pcnt > PD) ? PD : n_pcnt;
                            cmd.ovf_all = (n_pcnt > PD);
                            n_pcnt      = '0;
                        end
                        cmd.ops.chr = 1'b1;
                        cmd.char_b  = c;
                        n_mode = (c == olt_pkg::CH_QUOTE) ? olt_pkg::M_QUOTE : olt_pkg::M_TOKEN;
                    end
                end else if (n_mode == olt_pkg::M_TOKEN) begin
                    if (olt_pkg::is_ws(c)) begin
                        if (n_pcnt < PD) begin
                            cmd.push      = 1'b1;
                            cmd.push_idx  = n_pcnt;
                            cmd.push_char = c;
                            n_pcnt        = n_pcnt + 1'b1;
                        end else begin
                            n_pcnt = PD + 1'b1;
                        end
                    end else if (c == olt_pkg::CH_COMMA) begin
                        cmd.ovf_drop = cmd.ovf_drop || (n_pcnt > PD);
                        n_pcnt       = '0;
                        cmd.ops.tend = 1'b1;
                        n_mode       = olt_pkg::M_EMPTY;
                        n_first      = 1'b0;
                    end else begin
                        if (n_pcnt != '0) begin
                            cmd.flush_n = (n_pcnt > PD) ? PD : n_pcnt;
                            cmd.ovf_all = (n_pcnt > PD);
                            n_pcnt      = '0;
                        end
                        cmd.ops.chr = 1'b1;
                        cmd.char_b  = c;
                        if (c == olt_pkg::CH_QUOTE) begin
                            n_mode = olt_pkg::M_QUOTE;
                        end
                    end
                end else begin
                    cmd.ops.chr = 1'b1;
                    cmd.char_b  = c;
                    if (c == olt_pkg::CH_QUOTE) begin
                        n_mode = olt_pkg::M_TOKEN;
                    end
                end
            end

            if (do_endline) begin
                if (n_mode != olt_pkg::M_EMPTY) begin
                    // An open quote is closed before the token end.
                    if (n_mode == olt_pkg::M_QUOTE) begin
                        cmd.ops.chr = 1'b1;
                        cmd.char_b  = olt_pkg::CH_QUOTE;
                    end
                    cmd.ovf_drop = cmd.ovf_drop || (n_pcnt > PD);
                    cmd.ops.tend = 1'b1;
                end
                cmd.ops.lend = 1'b1;
                do_reset     = 1'b1;
            end

            if (do_reset) begin
                n_mode  = olt_pkg::M_EMPTY;
                n_held  = 1'b0;
                n_rawbs = 1'b0;
                n_incom = 1'b0;
                n_first = 1'b1;
                n_kept  = 8'd0;
                n_pcnt  = '0;
                n_level = 8'd0;
            end
        end

        cmd.tab  = r_level;
        cmd.line = n_nl;
    end

    assign o_q_cmd  = cmd;
    assign o_q_push = accept && ((cmd.ops != '0) || cmd.push || (cmd.flush_n != '0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= 8'd255;
            r_mode  <= olt_pkg::M_EMPTY;
            r_held  <= 1'b0;
            r_rawbs <= 1'b0;
            r_incom <= 1'b0;
            r_first <= 1'b1;
            r_kept  <= 8'd0;
            r_pcnt  <= '0;
            r_level <= 8'd0;
            r_nl    <= 16'd0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            r_mode  <= n_mode;
            r_held  <= n_held;
            r_rawbs <= n_rawbs;
            r_incom <= n_incom;
            r_first <= n_first;
            r_kept  <= n_kept;
            r_pcnt  <= n_pcnt;
            r_level <= n_level;
            r_nl    <= n_nl;
        end
    end

endmodule

[design/olt_back.sv]
module olt_back #(
    parameter int PENDING_DEPTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  olt_pkg::t_cmd i_q_head,
    input  logic          i_q_empty,
    output logic          o_q_pop,
    olt_out_if.source     o_out
);

    localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

    olt_pkg::t_back_state        r_state, n_state;
    olt_pkg::t_cmd               r_cmd,   n_cmd;
    olt_pkg::t_ops               r_ops,   n_ops;
    logic [olt_pkg::PCNT_W-1:0]  r_idx,   n_idx;

    logic                        r_out_valid, n_out_valid;
    logic [7:0]                  r_out_char,  n_out_char;
    logic [1:0]                  r_out_kind,  n_out_kind;
    logic [7:0]                  r_out_tab,   n_out_tab;
    logic [15:0]                 r_out_line,  n_out_line;
    logic                        r_out_ovf,   n_out_ovf;
    logic                        r_out_last,  n_out_last;

    logic                        out_free;
    logic                        flush_end;
    logic                        wr_en;
    logic [7:0]                  rd_data;

    assign out_free  = !r_out_valid || o_out.ready;
    assign flush_end = (r_idx == r_cmd.flush_n - 1'b1);

    olt_ram #(
        .WIDTH (8),
        .DEPTH (PENDING_DEPTH)
    ) u_pend_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_cmd.push_idx[AW-1:0]),
        .i_wr_data (r_cmd.push_char),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            olt_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    n_state = (i_q_head.flush_n != '0) ? olt_pkg::BK_FLUSH_RD : olt_pkg::BK_OPS;
                end
            end
            olt_pkg::BK_FLUSH_RD: begin
                n_state = olt_pkg::BK_FLUSH_EMIT;
            end
            olt_pkg::BK_FLUSH_EMIT: begin
                if (out_free) begin
                    n_state = flush_end ? olt_pkg::BK_OPS : olt_pkg::BK_FLUSH_RD;
                end
            end
            olt_pkg::BK_OPS: begin
                if (r_ops == '0) begin
                    n_state = olt_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = olt_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb begin
        logic load;

        load        = 1'b0;
        n_cmd       = r_cmd;
        n_ops       = r_ops;
        n_idx       = r_idx;
        o_q_pop     = 1'b0;
        wr_en       = 1'b0;
        n_out_char  = r_out_char;
        n_out_kind  = r_out_kind;
        n_out_ovf   = r_out_ovf;
        n_out_last  = r_out_last;

        unique case (r_state)
            olt_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_head;
                    n_ops   = i_q_head.ops;
                    n_idx   = '0;
                end
            end
            olt_pkg::BK_FLUSH_RD: begin
            end
            olt_pkg::BK_FLUSH_EMIT: begin
                if (out_free) begin
                    load       = 1'b1;
                    n_out_char = rd_data;
                    n_out_kind = olt_pkg::K_CHAR;
                    n_out_ovf  = r_cmd.ovf_all;
                    n_out_last = flush_end && (r_ops == '0);
                    n_idx      = r_idx + 1'b1;
                end
            end
            olt_pkg::BK_OPS: begin
                if (r_ops == '0) begin
                    // Whitespace into the pending store is written after any flush read.
                    wr_en = r_cmd.push;
                end else if (out_free) begin
                    load       = 1'b1;
                    n_out_char = 8'd0;
                    n_out_ovf  = r_cmd.ovf_all;
                    if (r_ops.bslash) begin
                        n_ops.bslash = 1'b0;
                        n_out_char   = olt_pkg::CH_BSLASH;
                        n_out_kind   = olt_pkg::K_CHAR;
                    end else if (r_ops.chr) begin
                        n_ops.chr  = 1'b0;
                        n_out_char = r_cmd.char_b;
                        n_out_kind = olt_pkg::K_CHAR;
                    end else if (r_ops.tend) begin
                        n_ops.tend = 1'b0;
                        n_out_kind = olt_pkg::K_TEND;
                        n_out_ovf  = r_cmd.ovf_all || r_cmd.ovf_drop;
                    end else if (r_ops.lend) begin
                        n_ops.lend = 1'b0;
                        n_out_kind = olt_pkg::K_LEND;
                        n_out_ovf  = r_cmd.ovf_all || r_cmd.ovf_drop;
                    end else begin
                        n_ops.eof  = 1'b0;
                        n_out_kind = olt_pkg::K_EOF;
                    end
                    n_out_last = (n_ops == '0);
                end
            end
            default: begin
            end
        endcase

        if (load) begin
            n_out_valid = 1'b1;
            n_out_tab   = r_cmd.tab;
            n_out_line  = r_cmd.line;
        end else begin
            n_out_valid = r_out_valid && !o_out.ready;
            n_out_tab   = r_out_tab;
            n_out_line  = r_out_line;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= olt_pkg::BK_IDLE;
            r_ops       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ops       <= n_ops;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_out_char <= n_out_char;
        r_out_kind <= n_out_kind;
        r_out_tab  <= n_out_tab;
        r_out_line <= n_out_line;
        r_out_ovf  <= n_out_ovf;
        r_out_last <= n_out_last;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_char    = r_out_char;
    assign o_out.kind        = r_out_kind;
    assign o_out.tab_level   = r_out_tab;
    assign o_out.line_count  = r_out_line;
    assign o_out.ws_overflow = r_out_ovf;
    assign o_out.last        = r_out_last;

endmodule

[design/outline_line_tokenizer_top.sv]
// Outline line tokenizer.
// Input channel i_in carries one raw text byte per transaction, or an end-of-file
// marker. Output channel o_out carries token characters, token ends, line ends and
// the end-of-file result; last marks the final result caused by one input byte.
// i_cfg_we/i_cfg_wdata write the line limit; write it only while the block is idle.
// The front end classifies each byte in the cycle it is accepted and places a
// command in a four-entry queue; it takes a byte every cycle while the queue has room.
// The back end turns each command into results through a one-entry output register.
// The back end takes a command from the queue, flushes any held whitespace (each
// character a pending-store read, then output), emits the other results one by
// one, and closes the command, writing any new whitespace into the pending store.
// A byte that produces no result and stores no whitespace is handled by the front
// end alone; it places no command in the queue.
// When the receiver stalls, the output register holds, the back end waits, and
// the queue fills until i_in.ready drops.
// Reset clears the line state, the line counter, the command queue and the output
// register, and sets the line limit to 255. The pending-whitespace store is not cleared.
module outline_line_tokenizer_top #(
    parameter int LINE_BUF_LEN  = 256,
    parameter int PENDING_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    olt_in_if.sink     i_in,
    olt_out_if.source  o_out
);

    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_empty;
    olt_pkg::t_cmd q_cmd;
    olt_pkg::t_cmd q_head;

    olt_front #(
        .LINE_BUF_LEN  (LINE_BUF_LEN),
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_cmd     (q_cmd)
    );

    olt_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty)
    );

    olt_back #(
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_head  (q_head),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule

[tb/sv/outline_token_checker.sv]
`timescale 1ns / 100ps

module outline_token_checker #(
    parameter int PEND_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    olt_in_if          i_in,
    olt_out_if         i_out,
    output int         o_fail_count,
    output int         o_open_count,
    output int         o_checked_count,
    output int         o_line_end_count,
    output int         o_overflow_count
);

    typedef struct packed {
        logic [7:0]  chr;
        logic [1:0]  kind;
        logic [7:0]  tab;
        logic [15:0] line;
        logic        ovf;
        logic        last;
    } t_token_result;

    t_token_result expected_results[$];
    t_token_result step_results[$];

    // Shadow copy of the tokenizer's line state.
    logic [7:0]     limit_reg;
    olt_pkg::t_mode mode;
    logic           bslash_held;
    logic           prev_was_bslash;
    logic           comment_on;
    logic           on_first_token;
    logic [7:0]     kept_bytes;
    logic [7:0]     held_space [PEND_DEPTH];
    int             held_count;
    logic [7:0]     tab_depth;
    logic [15:0]    newline_total;
    logic           step_ovf;

    int fail_total     = 0;
    int open_total     = 0;
    int checked_total  = 0;
    int line_end_total = 0;
    int overflow_total = 0;

    assign o_fail_count     = fail_total;
    assign o_open_count     = open_total;
    assign o_checked_count  = checked_total;
    assign o_line_end_count = line_end_total;
    assign o_overflow_count = overflow_total;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic void emit_result(input logic [1:0] kind, input logic [7:0] c);
        t_token_result r;
        r.chr  = (kind == olt_pkg::K_CHAR) ? c : 8'h00;
        r.kind = kind;
        r.tab  = tab_depth;
        r.line = newline_total;
        r.ovf  = step_ovf;
        r.last = 1'b0;
        step_results.push_back(r);
    endfunction

    function automatic void hold_space(input logic [7:0] c);
        if (held_count < PEND_DEPTH) begin
            held_space[held_count] = c;
            held_count++;
        end else begin
            held_count = PEND_DEPTH + 1;
        end
    endfunction

    function automatic void drop_space();
        if (held_count > PEND_DEPTH) step_ovf = 1'b1;
        held_count = 0;
    endfunction

    function automatic void flush_space();
        int n;
        n = (held_count > PEND_DEPTH) ? PEND_DEPTH : held_count;
        if (held_count > PEND_DEPTH) step_ovf = 1'b1;
        for (int i = 0; i < n; i++) emit_result(olt_pkg::K_CHAR, held_space[i]);
        held_count = 0;
    endfunction

    function automatic void close_token();
        drop_space();
        emit_result(olt_pkg::K_TEND, 8'h00);
        mode = olt_pkg::M_EMPTY;
        on_first_token = 1'b0;
    endfunction

    function automatic void parse_char(input logic [7:0] c);
        if (mode == olt_pkg::M_EMPTY || mode == olt_pkg::M_SPACE) begin
            if (is_blank(c)) begin
                // Only tabs ahead of the first token set the indent level.
                if (on_first_token && c == olt_pkg::CH_TAB && tab_depth < 8'd255) tab_depth++;
                mode = olt_pkg::M_SPACE;
                return;
            end
            if (c == olt_pkg::CH_COMMA) begin
                close_token();
                return;
            end
            mode = olt_pkg::M_TOKEN;
        end
        if (mode == olt_pkg::M_TOKEN) begin
            if (is_blank(c)) begin
                hold_space(c);
            end else if (c == olt_pkg::CH_COMMA) begin
                close_token();
            end else begin
                flush_space();
                emit_result(olt_pkg::K_CHAR, c);
                if (c == olt_pkg::CH_QUOTE) mode = olt_pkg::M_QUOTE;
            end
            return;
        end
        emit_result(olt_pkg::K_CHAR, c);
        if (c == olt_pkg::CH_QUOTE) mode = olt_pkg::M_TOKEN;
    endfunction

    function automatic void release_bslash();
        if (bslash_held) begin
            bslash_held = 1'b0;
            parse_char(olt_pkg::CH_BSLASH);
        end
    endfunction

    function automatic void clear_line();
        mode            = olt_pkg::M_EMPTY;
        bslash_held     = 1'b0;
        prev_was_bslash = 1'b0;
        comment_on      = 1'b0;
        on_first_token  = 1'b1;
        kept_bytes      = 8'd0;
        held_count      = 0;
        tab_depth       = 8'd0;
    endfunction

    function automatic void close_line();
        if (mode != olt_pkg::M_EMPTY) begin
            if (mode == olt_pkg::M_QUOTE) emit_result(olt_pkg::K_CHAR, olt_pkg::CH_QUOTE);
            drop_space();
            emit_result(olt_pkg::K_TEND, 8'h00);
        end
        emit_result(olt_pkg::K_LEND, 8'h00);
        clear_line();
    endfunction

    function automatic void predict_byte(input logic [7:0] c, input logic eof);
        logic was_bslash;
        step_results.delete();
        step_ovf = 1'b0;
        if (eof) begin
            emit_result(olt_pkg::K_EOF, 8'h00);
            clear_line();
        end else if (c == olt_pkg::CH_NL) begin
            newline_total++;
            if (prev_was_bslash) begin
                // Line continuation: a kept backslash disappears and frees its slot.
                if (bslash_held) begin
                    bslash_held = 1'b0;
                    if (kept_bytes > 0) kept_bytes--;
                end
                prev_was_bslash = 1'b0;
            end else begin
                if (!comment_on) release_bslash();
                close_line();
            end
        end else begin
            was_bslash = (c == olt_pkg::CH_BSLASH);
            if (!comment_on && kept_bytes < limit_reg) begin
                if (c == olt_pkg::CH_HASH) begin
                    release_bslash();
                    comment_on = 1'b1;
                end else begin
                    kept_bytes++;
                    release_bslash();
                    if (c == olt_pkg::CH_BSLASH) bslash_held = 1'b1;
                    else if (c == olt_pkg::CH_NUL) comment_on = 1'b1;
                    else parse_char(c);
                end
            end
            prev_was_bslash = was_bslash;
        end
        if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
        foreach (step_results[i]) expected_results.push_back(step_results[i]);
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_total++;
        end
    endfunction

    function automatic void compare_result();
        t_token_result want;
        if (expected_results.size() == 0) begin
            $error("unexpected result: kind %0d char %0h", i_out.kind, i_out.out_char);
            fail_total++;
        end else begin
            want = expected_results.pop_front();
            check_field("out_char", want.chr, i_out.out_char);
            check_field("kind", want.kind, i_out.kind);
            check_field("tab_level", want.tab, i_out.tab_level);
            check_field("line_count", want.line, i_out.line_count);
            check_field("ws_overflow", want.ovf, i_out.ws_overflow);
            check_field("last", want.last, i_out.last);
            checked_total++;
            if (want.kind == olt_pkg::K_LEND) line_end_total++;
            if (want.ovf) overflow_total++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            limit_reg     = 8'd255;
            newline_total = 16'd0;
            clear_line();
            expected_results.delete();
        end else begin
            if (i_cfg_we) limit_reg = i_cfg_wdata;
            if (i_out.valid && i_out.ready) compare_result();
            if (i_in.valid && i_in.ready) predict_byte(i_in.in_byte, i_in.end_of_file);
        end
        open_total = expected_results.size();
    end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps

module testbench;

    localparam int RANDOM_ITEMS = 175;
    localparam int PHASES       = 5;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 80;

    logic       i_clk;
    logic       i_rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;

    olt_in_if  in_ch ();
    olt_out_if out_ch ();

    int fail_count;
    int open_count;
    int checked_count;
    int line_end_count;
    int overflow_count;

    int items_sent   = 0;
    bit idle_enable  = 1'b1;
    bit hold_request = 1'b0;

    outline_line_tokenizer_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    outline_token_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata),
        .i_in             (in_ch),
        .i_out            (out_ch),
        .o_fail_count     (fail_count),
        .o_open_count     (open_count),
        .o_checked_count  (checked_count),
        .o_line_end_count (line_end_count),
        .o_overflow_count (overflow_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("outline_line_tokenizer_top regression: fail");
        $finish;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] blank_byte();
        case ($urandom_range(0, 7))
            0, 1, 2: return 8'h20;
            3, 4:    return olt_pkg::CH_TAB;
            5:       return 8'h0B;
            6:       return 8'h0C;
            default: return 8'h0D;
        endcase
    endfunction

    initial begin : receiver
        int stall_left;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                // Long hold-off so the command queue fills and input ready drops.
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else if (idle_enable && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap();
                out_ch.ready <= (stall_left == 0);
                if (stall_left > 0) stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_item(input logic [7:0] b, input logic eof);
        int gap;
        in_ch.valid       <= 1'b1;
        in_ch.in_byte     <= b;
        in_ch.end_of_file <= eof;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
        gap = (idle_enable && !hold_request) ? pick_gap() : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
    endtask

    task automatic wait_quiet();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (open_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [7:0] value);
        wait_quiet();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // One logical line of mostly plausible outline text with random content.
    task automatic send_random_line();
        int tokens;
        int chars;
        int r;
        repeat ($urandom_range(0, 3)) send_item(blank_byte(), 1'b0);
        tokens = $urandom_range(1, 4);
        for (int t = 0; t < tokens; t++) begin
            if (t > 0) send_item(olt_pkg::CH_COMMA, 1'b0);
            chars = $urandom_range(0, 6);
            for (int k = 0; k < chars; k++) begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    send_item(8'($urandom_range(8'h61, 8'h7A)), 1'b0);
                end else if (r < 68) begin
                    send_item(blank_byte(), 1'b0);
                end else if (r < 74) begin
                    send_item(olt_pkg::CH_QUOTE, 1'b0);
                end else if (r < 79) begin
                    send_item(olt_pkg::CH_BSLASH, 1'b0);
                    if ($urandom_range(0, 1) != 0) send_item(olt_pkg::CH_NL, 1'b0);
                end else if (r < 82) begin
                    send_item(olt_pkg::CH_HASH, 1'b0);
                end else if (r < 84) begin
                    send_item(olt_pkg::CH_NUL, 1'b0);
                end else if (r < 93) begin
                    send_item(8'($urandom_range(0, 255)), 1'b0);
                end else if (r < 96) begin
                    // A whitespace run inside a token, often long enough to overflow the store.
                    send_item(8'h78, 1'b0);
                    repeat ($urandom_range(28, 40)) send_item(blank_byte(), 1'b0);
                    if ($urandom_range(0, 1) != 0) send_item(8'h79, 1'b0);
                end else begin
                    send_item(olt_pkg::CH_COMMA, 1'b0);
                end
            end
        end
        r = $urandom_range(0, 99);
        if (r < 8) send_item(olt_pkg::CH_COMMA, 1'b0);
        else if (r < 16) send_item(blank_byte(), 1'b0);
        if ($urandom_range(0, 99) < 4) send_item(8'($urandom_range(0, 255)), 1'b1);
        else send_item(olt_pkg::CH_NL, 1'b0);
    endtask

    initial begin : stimulus
        logic [7:0] limits [PHASES];
        int         phase_end;
        int         wait_cycles;

        i_rst_n           <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= 8'd0;
        in_ch.valid       <= 1'b0;
        in_ch.in_byte     <= 8'd0;
        in_ch.end_of_file <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Indent, a held blank, a continued line, 0xFF, an empty token, an open quote.
        send_text("\ta b\\\n ");
        send_item(8'hFF, 1'b0);
        send_text(", ,\"x,\n");
        // Trailing comma followed by a zero byte that hides the rest of the line.
        send_text("k,");
        send_item(olt_pkg::CH_NUL, 1'b0);
        send_text("r\n");
        // Blank remainder after the last comma, then end of file on an open line.
        send_text("p, \n");
        send_text("z");
        send_item(8'($urandom_range(0, 255)), 1'b1);

        // With a tiny limit: a kept backslash removed by a dropped one, and a dropped hash.
        write_limit(8'd2);
        send_text("a\\\\\nx#y\n");

        limits[0] = 8'd255;
        limits[1] = 8'd1;
        limits[2] = 8'd12;
        limits[3] = 8'd255;
        limits[4] = 8'($urandom_range(2, 60));
        for (int p = 0; p < PHASES; p++) begin
            write_limit(limits[p]);
            if (p == 0) hold_request = 1'b1;
            idle_enable = (p != 3);
            phase_end = items_sent + RANDOM_ITEMS / PHASES;
            while (items_sent < phase_end) send_random_line();
        end
        idle_enable = 1'b1;

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        wait_cycles = 0;
        while (open_count != 0 && wait_cycles < 200_000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (open_count != 0) $error("%0d expected results never arrived", open_count);

        $display("Sent %0d bytes under line limits 255, 2, 255, 1, 12, 255 and %0d.",
                 items_sent, limits[4]);
        $display("Checked %0d results: %0d line ends, %0d carrying whitespace overflow.",
                 checked_count, line_end_count, overflow_count);
        if (fail_count == 0 && open_count == 0) begin
            $display("outline_line_tokenizer_top regression: pass");
        end else begin
            $display("outline_line_tokenizer_top regression: fail");
        end
        $finish;
    end

endmodule
